>>> rtl/core/fbase_pkg.sv
// Shared types, constants and weight table for the Fibonacci-base encoder.
package fbase_pkg;

	localparam int VALUE_W       = 35;
	localparam int WEIGHT_W      = VALUE_W + 1;
	localparam int MAX_TERMS     = 64;
	localparam int MAX_IDX_W     = $clog2(MAX_TERMS);
	localparam int NUM_TERMS_DEF = 50;

	typedef logic [WEIGHT_W-1:0] weight_t;
	typedef weight_t weight_tbl_t [MAX_TERMS];

	typedef struct packed {
		logic start;
		logic special;
		logic step;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic idx_zero;
		logic special;
	} dp_sts_t;

	// saturates so that any weight beyond the input range still compares as larger
	function automatic weight_t sat_weight(input logic [63:0] f);
		if ((f >> WEIGHT_W) != 64'd0) begin
			return '1;
		end
		return f[WEIGHT_W-1:0];
	endfunction

	function automatic weight_tbl_t fib_table();
		weight_tbl_t t;
		logic [63:0] f [MAX_TERMS];
		for (int i = 0; i < MAX_TERMS; i++) begin
			f[i] = (i < 2) ? 64'd1 : f[i-1] + f[i-2];
			t[i] = sat_weight(f[i]);
		end
		return t;
	endfunction

	function automatic weight_t weight_sum(input int n);
		logic [63:0] f [MAX_TERMS];
		logic [63:0] s;
		s = 64'd0;
		for (int i = 0; i < MAX_TERMS; i++) begin
			f[i] = (i < 2) ? 64'd1 : f[i-1] + f[i-2];
			if (i < n) begin
				s = s + f[i];
			end
		end
		return sat_weight(s);
	endfunction

	localparam weight_tbl_t FIB_WEIGHTS = fib_table();

endpackage

>>> rtl/core/fbase_number_if.sv
// Request channel carrying the integer to convert.
interface fbase_number_if;
	logic                           valid;
	logic                           ready;
	logic [fbase_pkg::VALUE_W-1:0]  value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

>>> rtl/core/fbase_digit_if.sv
// Request channel carrying one Fibonacci-base digit.
interface fbase_digit_if;
	logic valid;
	logic ready;
	logic digit;
	logic last;
	logic too_large;

	modport source (output valid, output digit, output last, output too_large, input ready);
	modport sink (input valid, input digit, input last, input too_large, output ready);
endinterface

>>> rtl/core/fbase_datapath.sv
// Remainder, weight index and output register of the Fibonacci-base encoder.
module fbase_datapath #(
	parameter int NUM_TERMS = fbase_pkg::NUM_TERMS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fbase_pkg::ctl_cmd_t           cmd,
	output fbase_pkg::dp_sts_t            sts,
	input  logic [fbase_pkg::VALUE_W-1:0] value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          digit,
	output logic                          last,
	output logic                          too_large
);
	import fbase_pkg::*;

	localparam int      IDX_W = $clog2(NUM_TERMS);
	localparam weight_t W_SUM = weight_sum(NUM_TERMS);

	logic [VALUE_W-1:0] rem_q;
	logic [IDX_W-1:0]   idx_q;
	logic               started_q;
	logic               out_valid_q;
	logic               digit_q;
	logic               last_q;
	logic               too_large_q;

	weight_t            w_cur;
	logic               take;
	logic               emit;
	logic               idx_zero;
	logic               out_free;
	logic               is_zero;

	assign w_cur    = FIB_WEIGHTS[MAX_IDX_W'(idx_q)];
	assign take     = w_cur <= {1'b0, rem_q};
	assign emit     = started_q | take;
	assign idx_zero = idx_q == '0;
	assign out_free = !out_valid_q || out_ready;
	assign is_zero  = value == '0;

	assign sts.out_free = out_free;
	assign sts.idx_zero = idx_zero;
	assign sts.special  = is_zero || ({1'b0, value} > W_SUM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			started_q <= 1'b0;
		end else if (cmd.start) begin
			idx_q     <= IDX_W'(NUM_TERMS - 1);
			started_q <= 1'b0;
		end else if (cmd.step) begin
			started_q <= emit;
			if (!idx_zero) begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= value;
		end else if (cmd.step && take) begin
			rem_q <= rem_q - w_cur[VALUE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.special || (cmd.step && emit)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.special) begin
			digit_q     <= 1'b0;
			last_q      <= 1'b1;
			too_large_q <= !is_zero;
		end else if (cmd.step && emit) begin
			digit_q     <= take;
			last_q      <= idx_zero;
			too_large_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign digit     = digit_q;
	assign last      = last_q;
	assign too_large = too_large_q;

	a_flag_is_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && too_large_q) |-> (last_q && !digit_q))
		else $error("flagged result not a lone zero digit");

	a_step_runs_to_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && idx_zero) |-> emit)
		else $error("scan ended without emitting the final digit");

endmodule

>>> rtl/core/fbase_ctrl.sv
// Sequencing state machine of the Fibonacci-base encoder.
module fbase_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fbase_pkg::dp_sts_t  sts,
	output fbase_pkg::ctl_cmd_t cmd
);
	import fbase_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.start   = 1'b0;
		cmd.special = 1'b0;
		cmd.step    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = sts.out_free;
				if (in_valid && sts.out_free) begin
					if (sts.special) begin
						cmd.special = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				if (sts.out_free) begin
					cmd.step = 1'b1;
					if (sts.idx_zero) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == ST_IDLE))
		else $error("request taken during a scan");

	a_step_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step || cmd.start || cmd.special) |-> sts.out_free)
		else $error("output register overwritten");

endmodule

>>> rtl/core/integer_to_fibonacci_base.sv
// Top level of the integer to Fibonacci-base (greedy Zeckendorf) encoder.
//
// number : request carrying a 35-bit unsigned value.
// digits : one request per digit, most significant first; leading zeros are
//          dropped and the digit of weight index 0 carries last. A zero value
//          gives one 0 digit; a value above the sum of all NUM_TERMS weights
//          gives one result with too_large set and digit 0.
// Timing: a conversion scans the weight table from index NUM_TERMS-1 down to
// 0, one compare and subtract per cycle while the output register has room;
// the zero and too-large cases skip the scan. The first digit is registered
// and appears in the cycle after the scan reaches the highest weight taken.
// A new value is taken only once the previous conversion has finished.
// Receiver stall: the scan waits whenever the output register is full and not
// being taken; no digit is lost. Reset empties the output register and returns
// the controller to idle; no clearing pass is needed.
module integer_to_fibonacci_base #(
	parameter int NUM_TERMS = fbase_pkg::NUM_TERMS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	fbase_number_if.sink  number,
	fbase_digit_if.source digits
);
	import fbase_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	fbase_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (number.valid),
		.in_ready (number.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fbase_datapath #(
		.NUM_TERMS (NUM_TERMS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.value     (number.value),
		.out_valid (digits.valid),
		.out_ready (digits.ready),
		.digit     (digits.digit),
		.last      (digits.last),
		.too_large (digits.too_large)
	);

endmodule

>>> tb/integer_to_fibonacci_base_tb.sv
// Testbench for integer_to_fibonacci_base: predicted digit stream against the block.
`timescale 1ns / 100ps

module integer_to_fibonacci_base_tb;

	localparam int TERMS = fbase_pkg::NUM_TERMS_DEF;
	localparam int VW = fbase_pkg::VALUE_W;
	localparam int N_RANDOM = 310;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AT = 60;
	localparam int DRAIN_CYCLES = 2 * TERMS + 20;
	localparam longint CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic digit;
		logic last;
		logic too_large;
	} fib_digit_t;

	logic clk = 1'b0;
	logic arst_n;

	fbase_number_if num_if();
	fbase_digit_if dig_if();

	integer_to_fibonacci_base #(
		.NUM_TERMS(TERMS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.number(num_if),
		.digits(dig_if)
	);

	logic [63:0] fib_w [TERMS];
	logic [63:0] fib_total;

	logic [VW-1:0] values_due [$];
	fib_digit_t digits_due [$];

	int taken_cnt;
	int bad_cnt;
	longint cycles;
	logic in_fire;
	int hold_left;
	logic hold_done;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int tx_idle_pct(input int n);
		if (n < 110) begin
			return 25;
		end else if (n < 220) begin
			return 64;
		end
		return 0;
	endfunction

	function automatic int rx_idle_pct(input int n);
		if (n < 110) begin
			return 64;
		end else if (n < 220) begin
			return 25;
		end
		return 0;
	endfunction

	// greedy scan from the top weight, leading zeros dropped
	task automatic predict_digits(input logic [VW-1:0] v);
		logic [63:0] rem;
		logic take;
		logic begun;
		rem = 64'(v);
		begun = 1'b0;
		if (rem > fib_total) begin
			digits_due.push_back('{digit: 1'b0, last: 1'b1, too_large: 1'b1});
		end else if (rem == 64'd0) begin
			digits_due.push_back('{digit: 1'b0, last: 1'b1, too_large: 1'b0});
		end else begin
			for (int i = TERMS - 1; i >= 0; i--) begin
				take = (fib_w[i] <= rem);
				if (take) begin
					rem = rem - fib_w[i];
					begun = 1'b1;
				end
				if (begun) begin
					digits_due.push_back('{digit: take, last: (i == 0), too_large: 1'b0});
				end
			end
		end
	endtask

	function automatic logic [VW-1:0] wide_rand();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[VW-1:0];
	endfunction

	function automatic logic [VW-1:0] gen_value();
		int sel;
		logic [63:0] v;
		logic [63:0] span;
		sel = $urandom_range(99);
		if (sel < 30) begin
			v = 64'(wide_rand() >> $urandom_range(VW - 1, 0));
		end else if (sel < 70) begin
			v = 64'(wide_rand());
		end else if (sel < 85) begin
			v = fib_total - 64'($urandom_range(3000));
		end else if (sel < 95) begin
			span = (64'd1 << VW) - 64'd1 - fib_total;
			v = fib_total + 64'd1 + ({$urandom, $urandom} % span);
		end else begin
			v = fib_w[$urandom_range(TERMS - 1)] - 64'd1 + 64'($urandom_range(2));
		end
		return v[VW-1:0];
	endfunction

	// request side
	always @(negedge clk) begin
		if (!arst_n) begin
			num_if.valid <= 1'b0;
		end else if (!num_if.valid || in_fire) begin
			if (values_due.size() != 0 && $urandom_range(99) >= tx_idle_pct(taken_cnt)) begin
				num_if.valid <= 1'b1;
				num_if.value <= values_due[0];
			end else begin
				num_if.valid <= 1'b0;
				num_if.value <= wide_rand();
			end
		end
	end

	// digit side
	always @(negedge clk) begin
		if (!arst_n) begin
			dig_if.ready <= 1'b0;
		end else begin
			dig_if.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct(taken_cnt));
		end
	end

	// long receiver hold-off so the block backs up
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && taken_cnt >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			in_fire <= 1'b0;
			taken_cnt <= 0;
		end else begin
			in_fire <= num_if.valid && num_if.ready;
			if (num_if.valid && num_if.ready) begin
				predict_digits(num_if.value);
				void'(values_due.pop_front());
				taken_cnt <= taken_cnt + 1;
			end
			if (dig_if.valid && dig_if.ready) begin
				if (digits_due.size() == 0) begin
					bad_cnt = bad_cnt + 1;
					if (bad_cnt <= 10) begin
						$display("%0t: unexpected digit %b last %b too_large %b", $realtime,
							dig_if.digit, dig_if.last, dig_if.too_large);
					end
				end else begin
					if (dig_if.digit !== digits_due[0].digit ||
						dig_if.last !== digits_due[0].last ||
						dig_if.too_large !== digits_due[0].too_large) begin
						bad_cnt = bad_cnt + 1;
						if (bad_cnt <= 10) begin
							$display("%0t: digit mismatch exp d=%b l=%b t=%b got d=%b l=%b t=%b",
								$realtime, digits_due[0].digit, digits_due[0].last,
								digits_due[0].too_large, dig_if.digit, dig_if.last,
								dig_if.too_large);
						end
					end
					void'(digits_due.pop_front());
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		logic [63:0] zeck_top;
		cycles = 0;
		bad_cnt = 0;
		arst_n = 1'b0;
		num_if.valid = 1'b0;
		num_if.value = '0;
		dig_if.ready = 1'b0;
		fib_total = 64'd0;
		for (int i = 0; i < TERMS; i++) begin
			fib_w[i] = (i < 2) ? 64'd1 : fib_w[i-1] + fib_w[i-2];
			fib_total = fib_total + fib_w[i];
		end
		zeck_top = fib_w[TERMS-1] + fib_w[TERMS-2] - 64'd1;

		values_due.push_back('0);
		values_due.push_back(VW'(1));
		values_due.push_back(VW'(2));
		values_due.push_back(VW'(3));
		values_due.push_back(VW'(4));
		values_due.push_back(VW'(fib_w[TERMS-1] - 64'd1));
		values_due.push_back(VW'(fib_w[TERMS-1]));
		values_due.push_back(VW'(fib_w[TERMS-1] + 64'd1));
		values_due.push_back(VW'(zeck_top));
		values_due.push_back(VW'(zeck_top + 64'd1));
		values_due.push_back(VW'(fib_total - 64'd1));
		values_due.push_back(VW'(fib_total));
		values_due.push_back(VW'(fib_total + 64'd1));
		values_due.push_back('1);
		values_due.push_back({1'b1, {(VW-1){1'b0}}});
		values_due.push_back(VW'(35'h2_AAAA_AAAA));
		values_due.push_back(VW'(35'h5_5555_5555));
		values_due.push_back(VW'(35'h0_FFFF_FFFF));
		values_due.push_back(VW'(fib_w[TERMS/2]));
		values_due.push_back(VW'(fib_w[TERMS/2] + fib_w[TERMS/2 - 1]));

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// sender pause: let every digit of the directed set drain
		while (values_due.size() != 0 || digits_due.size() != 0 || num_if.valid) begin
			@(posedge clk);
		end

		for (int k = 0; k < N_RANDOM; k++) begin
			values_due.push_back(gen_value());
		end

		while (values_due.size() != 0 || digits_due.size() != 0 || num_if.valid) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (bad_cnt == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
